FILE: hw/rtl/jsu_pkg.sv
// Shared types, codes and character constants of the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned RUN_MAX = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;

  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_LOWER_B   = 8'h62;
  localparam logic [BYTE_W-1:0] CH_LOWER_F   = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LOWER_N   = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LOWER_R   = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LOWER_T   = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LOWER_U   = 8'h75;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] CH_FORMFEED  = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;

  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_CLOSED     = 3'd1,
    ST_BAD_ESCAPE = 3'd2,
    ST_BAD_HEX    = 3'd3,
    ST_ENDED      = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]                    count;
    logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
    status_t                       status;
    logic [COUNT_W-1:0]            line;
    logic [COUNT_W-1:0]            column;
  } run_t;

endpackage

FILE: hw/rtl/jsu_stream_ifs.sv
// Valid/ready channel interfaces for text input words and decoded output words.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  status;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_of_run;

  modport source (output valid, output out_byte, output status, output line_number,
                  output column_number, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input status, input line_number,
                  input column_number, input last_of_run, output ready);
endinterface

FILE: hw/rtl/jsu_decode.sv
// Input register, scan state and per-word decode into a run of up to three results.
module jsu_decode
  import jsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              end_of_text,
  output logic              run_valid,
  input  logic              run_ready,
  output run_t              run
);

  typedef enum logic [1:0] {
    MODE_OUTSIDE = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_ESCAPE  = 2'd2,
    MODE_HEX     = 2'd3
  } mode_t;

  logic               in_full;
  logic [BYTE_W-1:0]  in_byte;
  logic               in_end;

  mode_t              mode, mode_next;
  logic [1:0]         seen, seen_next;
  logic [15:0]        cp, cp_next;
  logic [COUNT_W-1:0] line, line_next;
  logic [COUNT_W-1:0] column, column_next;

  logic               hex_ok;
  logic [3:0]         hex_val;
  logic [15:0]        cp_shift;
  logic               fire;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_shift = {cp[11:0], hex_val};

  always_comb begin
    mode_next   = mode;
    seen_next   = seen;
    cp_next     = cp;
    line_next   = line;
    column_next = column;
    run.count   = 2'd0;
    run.bytes   = '0;
    run.status  = ST_BYTE;
    if (in_end) begin
      if (mode != MODE_OUTSIDE) begin
        run.count  = 2'd1;
        run.status = ST_ENDED;
        mode_next  = MODE_OUTSIDE;
        seen_next  = 2'd0;
        cp_next    = 16'd0;
      end
    end else begin
      if (column != COUNT_MAX) begin
        column_next = column + COUNT_ONE;
      end
      if (in_byte == CH_NEWLINE) begin
        column_next = COUNT_ONE;
        if (line != COUNT_MAX) begin
          line_next = line + COUNT_ONE;
        end
      end
      unique case (mode)
        MODE_OUTSIDE: begin
          if (in_byte == CH_QUOTE) begin
            mode_next = MODE_STRING;
          end
        end
        MODE_STRING: begin
          if (in_byte == CH_QUOTE) begin
            run.count  = 2'd1;
            run.status = ST_CLOSED;
            mode_next  = MODE_OUTSIDE;
            seen_next  = 2'd0;
            cp_next    = 16'd0;
          end else if (in_byte == CH_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end else begin
            run.count    = 2'd1;
            run.bytes[0] = in_byte;
          end
        end
        MODE_ESCAPE: begin
          mode_next = MODE_STRING;
          run.count = 2'd1;
          unique case (in_byte)
            CH_QUOTE:     run.bytes[0] = CH_QUOTE;
            CH_SLASH:     run.bytes[0] = CH_SLASH;
            CH_BACKSLASH: run.bytes[0] = CH_BACKSLASH;
            CH_LOWER_B:   run.bytes[0] = CH_BACKSPACE;
            CH_LOWER_F:   run.bytes[0] = CH_FORMFEED;
            CH_LOWER_N:   run.bytes[0] = CH_NEWLINE;
            CH_LOWER_R:   run.bytes[0] = CH_RETURN;
            CH_LOWER_T:   run.bytes[0] = CH_TAB;
            CH_LOWER_U: begin
              run.count = 2'd0;
              mode_next = MODE_HEX;
              seen_next = 2'd0;
              cp_next   = 16'd0;
            end
            default: begin
              run.status = ST_BAD_ESCAPE;
              mode_next  = MODE_OUTSIDE;
              seen_next  = 2'd0;
              cp_next    = 16'd0;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            run.count  = 2'd1;
            run.status = ST_BAD_HEX;
            mode_next  = MODE_OUTSIDE;
            seen_next  = 2'd0;
            cp_next    = 16'd0;
          end else if (seen == 2'd3) begin
            mode_next = MODE_STRING;
            seen_next = 2'd0;
            cp_next   = 16'd0;
            if (cp_shift <= 16'h007F) begin
              run.count    = 2'd1;
              run.bytes[0] = cp_shift[7:0];
            end else if (cp_shift <= 16'h07FF) begin
              run.count    = 2'd2;
              run.bytes[0] = 8'hC0 | {3'd0, cp_shift[10:6]};
              run.bytes[1] = 8'h80 | {2'd0, cp_shift[5:0]};
            end else begin
              run.count    = 2'd3;
              run.bytes[0] = 8'hE0 | {4'd0, cp_shift[15:12]};
              run.bytes[1] = 8'h80 | {2'd0, cp_shift[11:6]};
              run.bytes[2] = 8'h80 | {2'd0, cp_shift[5:0]};
            end
          end else begin
            seen_next = seen + 2'd1;
            cp_next   = cp_shift;
          end
        end
        default: begin
          mode_next = MODE_OUTSIDE;
        end
      endcase
    end
    run.line   = line_next;
    run.column = column_next;
  end

  assign fire      = in_full && (run.count == 2'd0 || run_ready);
  assign run_valid = in_full && (run.count != 2'd0);
  assign in_ready  = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      mode    <= MODE_OUTSIDE;
      seen    <= 2'd0;
      cp      <= 16'd0;
      line    <= COUNT_ONE;
      column  <= COUNT_ONE;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (fire) begin
        mode   <= mode_next;
        seen   <= seen_next;
        cp     <= cp_next;
        line   <= line_next;
        column <= column_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= text_byte;
      in_end  <= end_of_text;
    end
  end

endmodule

FILE: hw/rtl/jsu_serialize.sv
// Result register that holds one run and hands its words out one per cycle while out_ready is high.
module jsu_serialize
  import jsu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               run_valid,
  output logic               run_ready,
  input  run_t               run,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [2:0]         status,
  output logic [COUNT_W-1:0] line_number,
  output logic [COUNT_W-1:0] column_number,
  output logic               last_of_run
);

  logic [1:0]                     remaining;
  logic [1:0]                     idx;
  logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
  status_t                        held_status;
  logic [COUNT_W-1:0]             held_line;
  logic [COUNT_W-1:0]             held_column;

  assign out_valid     = remaining != 2'd0;
  assign last_of_run   = remaining == 2'd1;
  assign run_ready     = remaining == 2'd0 || (last_of_run && out_ready);
  assign status        = held_status;
  assign line_number   = held_line;
  assign column_number = held_column;

  always_comb begin
    unique case (idx)
      2'd0:    out_byte = bytes[0];
      2'd1:    out_byte = bytes[1];
      2'd2:    out_byte = bytes[2];
      default: out_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      idx       <= 2'd0;
    end else if (run_valid && run_ready) begin
      remaining <= run.count;
      idx       <= 2'd0;
    end else if (out_valid && out_ready) begin
      remaining <= remaining - 2'd1;
      idx       <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (run_valid && run_ready) begin
      bytes       <= run.bytes;
      held_status <= run.status;
      held_line   <= run.line;
      held_column <= run.column;
    end
  end

endmodule

FILE: hw/rtl/json_string_unescape_core.sv
// Top level of the streaming JSON string unescaper.
//   channel  | dir | word
//   in_ch    | in  | text_byte, end_of_text
//   out_ch   | out | out_byte, status, line_number, column_number, last_of_run
// One input word is taken per cycle while the result register keeps up; a word's
// results pass through the input register and then the result register. A \uXXXX escape
// yields up to three output words, one per cycle while out_ch is ready, from the result
// register, and input waits only while that run is still being drained.
// Reset clears the scan state, the position to line 1 column 1, and empties both registers.
// A stall on out_ch backs up through the result register into the input register.
module json_string_unescape_core
  import jsu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic run_valid;
  logic run_ready;
  run_t run;

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .text_byte   (in_ch.text_byte),
    .end_of_text (in_ch.end_of_text),
    .run_valid   (run_valid),
    .run_ready   (run_ready),
    .run         (run)
  );

  jsu_serialize u_serialize (
    .clk           (clk),
    .rst           (rst),
    .run_valid     (run_valid),
    .run_ready     (run_ready),
    .run           (run),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .status        (out_ch.status),
    .line_number   (out_ch.line_number),
    .column_number (out_ch.column_number),
    .last_of_run   (out_ch.last_of_run)
  );

endmodule

FILE: dv/json_string_unescape_core_tb.sv
// Testbench for json_string_unescape_core: directed and random JSON strings checked against a predictor.
`timescale 1ns / 1ps

module json_string_unescape_core_tb
  import jsu_pkg::*;
;

  localparam int ITEM_TARGET    = 310;
  localparam int HOLD_CYCLES    = 150;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Q = 8'h71;

  localparam logic [7:0] SIMPLE_ESCAPES [8] = '{CH_QUOTE, CH_SLASH, CH_BACKSLASH,
      CH_LOWER_B, CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T};
  localparam logic [15:0] CP_EDGES [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
      16'h0800, 16'hFFFF};

  typedef enum logic [1:0] {
    SCAN_OUTSIDE,
    SCAN_STRING,
    SCAN_ESCAPE,
    SCAN_HEX
  } scan_mode_t;

  typedef struct {
    logic [7:0]  data;
    status_t     status;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;
  } decoded_word_t;

  class unescape_scoreboard;
    decoded_word_t expected_words[$];
    decoded_word_t run_words[$];
    scan_mode_t    mode;
    logic [1:0]    hex_count;
    logic [15:0]   code_acc;
    logic [15:0]   line_pos;
    logic [15:0]   col_pos;
    int            mismatches;
    int            checked;

    function new();
      leave_string();
      line_pos   = COUNT_ONE;
      col_pos    = COUNT_ONE;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void leave_string();
      mode      = SCAN_OUTSIDE;
      hex_count = 2'd0;
      code_acc  = 16'd0;
    endfunction

    function void push_result(logic [7:0] data, status_t status);
      decoded_word_t w;
      w.data   = data;
      w.status = status;
      w.line   = line_pos;
      w.column = col_pos;
      w.last   = 1'b0;
      run_words.push_back(w);
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_0 + 8'd9) return int'(c - CH_DIGIT_0);
      if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return int'(c - CH_LOWER_A) + 10;
      if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return int'(c - CH_UPPER_A) + 10;
      return -1;
    endfunction

    function void encode_utf8(logic [15:0] cp);
      if (cp <= 16'h007F) begin
        push_result(cp[7:0], ST_BYTE);
      end else if (cp <= 16'h07FF) begin
        push_result({3'b110, cp[10:6]}, ST_BYTE);
        push_result({2'b10, cp[5:0]}, ST_BYTE);
      end else begin
        push_result({4'b1110, cp[15:12]}, ST_BYTE);
        push_result({2'b10, cp[11:6]}, ST_BYTE);
        push_result({2'b10, cp[5:0]}, ST_BYTE);
      end
    endfunction

    function void note_word(logic [7:0] c, logic ended);
      int h;
      run_words.delete();
      if (ended) begin
        if (mode != SCAN_OUTSIDE) begin
          push_result(8'h00, ST_ENDED);
          leave_string();
        end
      end else begin
        if (col_pos != COUNT_MAX) col_pos++;
        if (c == CH_NEWLINE) begin
          col_pos = COUNT_ONE;
          if (line_pos != COUNT_MAX) line_pos++;
        end
        case (mode)
          SCAN_OUTSIDE: begin
            if (c == CH_QUOTE) mode = SCAN_STRING;
          end
          SCAN_STRING: begin
            if (c == CH_QUOTE) begin
              push_result(8'h00, ST_CLOSED);
              leave_string();
            end else if (c == CH_BACKSLASH) begin
              mode = SCAN_ESCAPE;
            end else begin
              push_result(c, ST_BYTE);
            end
          end
          SCAN_ESCAPE: begin
            mode = SCAN_STRING;
            case (c)
              CH_QUOTE, CH_SLASH, CH_BACKSLASH: push_result(c, ST_BYTE);
              CH_LOWER_B: push_result(CH_BACKSPACE, ST_BYTE);
              CH_LOWER_F: push_result(CH_FORMFEED, ST_BYTE);
              CH_LOWER_N: push_result(CH_NEWLINE, ST_BYTE);
              CH_LOWER_R: push_result(CH_RETURN, ST_BYTE);
              CH_LOWER_T: push_result(CH_TAB, ST_BYTE);
              CH_LOWER_U: begin
                mode      = SCAN_HEX;
                hex_count = 2'd0;
                code_acc  = 16'd0;
              end
              default: begin
                push_result(8'h00, ST_BAD_ESCAPE);
                leave_string();
              end
            endcase
          end
          default: begin
            h = hex_value(c);
            if (h < 0) begin
              push_result(8'h00, ST_BAD_HEX);
              leave_string();
            end else begin
              code_acc = {code_acc[11:0], h[3:0]};
              if (hex_count == 2'd3) begin
                encode_utf8(code_acc);
                hex_count = 2'd0;
                code_acc  = 16'd0;
                mode      = SCAN_STRING;
              end else begin
                hex_count++;
              end
            end
          end
        endcase
      end
      if (run_words.size() > 0) run_words[run_words.size() - 1].last = 1'b1;
      foreach (run_words[i]) expected_words.push_back(run_words[i]);
    endfunction

    task report(string msg);
      $display("MISMATCH word %0d: %s", checked, msg);
      mismatches++;
    endtask

    task check_word(logic [7:0] data, logic [2:0] status, logic [15:0] line,
                    logic [15:0] column, logic last);
      decoded_word_t want;
      checked++;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word data %0h status %0d", data, status));
        return;
      end
      want = expected_words.pop_front();
      if (data !== want.data)
        report($sformatf("out_byte %0h, want %0h", data, want.data));
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (line !== want.line)
        report($sformatf("line_number %0d, want %0d", line, want.line));
      if (column !== want.column)
        report($sformatf("column_number %0d, want %0d", column, want.column));
      if (last !== want.last)
        report($sformatf("last_of_run %0b, want %0b", last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  unescape_scoreboard decoder_model;
  int   words_sent = 0;
  int   quiet_cycles = 0;
  logic steady = 1'b0;
  logic hold_request = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      decoder_model.note_word(in_ch.text_byte, in_ch.end_of_text);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      decoder_model.check_word(out_ch.out_byte, out_ch.status, out_ch.line_number,
                               out_ch.column_number, out_ch.last_of_run);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (rst === 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic ended);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= ended;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_outside_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_QUOTE || b == CH_NEWLINE);
    send_word(b, 1'b0);
  endtask

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 'h7F));
      1: return 16'($urandom_range('h80, 'h7FF));
      2: return 16'($urandom_range('h800, 'hFFFF));
      3: return 16'($urandom_range('hD800, 'hDFFF));
      default: return CP_EDGES[$urandom_range(0, 5)];
    endcase
  endfunction

  // cut_at below 4 breaks the digits there, by end of text or by a non-hex byte
  task automatic send_unicode(input logic [15:0] value, input int cut_at, input logic cut_by_end);
    logic [7:0] b;
    logic [3:0] d;
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_LOWER_U, 1'b0);
    for (int i = 0; i < 4; i++) begin
      if (i == cut_at) begin
        if (cut_by_end) begin
          send_word(8'($urandom), 1'b1);
        end else begin
          do b = 8'($urandom); while (decoder_model.hex_value(b) >= 0);
          send_word(b, 1'b0);
        end
        return;
      end
      d = value[15 - 4*i -: 4];
      b = (d < 4'd10) ? CH_DIGIT_0 + d
                      : (($urandom_range(0, 1) != 0) ? CH_UPPER_A : CH_LOWER_A) + d - 8'd10;
      send_word(b, 1'b0);
    end
  endtask

  task automatic send_random_string();
    logic [7:0] b;
    logic       bad;
    send_word(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 7) == 0) b = CH_NEWLINE;
          else do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BACKSLASH);
          send_word(b, 1'b0);
        end
        4, 5, 6: begin
          send_word(CH_BACKSLASH, 1'b0);
          send_word(SIMPLE_ESCAPES[$urandom_range(0, 7)], 1'b0);
        end
        default: send_unicode(pick_code_point(), 4, 1'b0);
      endcase
    end
    case ($urandom_range(0, 19))
      16: begin
        do begin
          b   = 8'($urandom);
          bad = (b == CH_LOWER_U);
          foreach (SIMPLE_ESCAPES[i]) if (b == SIMPLE_ESCAPES[i]) bad = 1'b1;
        end while (bad);
        send_word(CH_BACKSLASH, 1'b0);
        send_word(b, 1'b0);
      end
      17: send_unicode(pick_code_point(), $urandom_range(0, 3), 1'b0);
      18: begin
        case ($urandom_range(0, 2))
          0: send_word(8'($urandom), 1'b1);
          1: begin
            send_word(CH_BACKSLASH, 1'b0);
            send_word(8'($urandom), 1'b1);
          end
          default: send_unicode(pick_code_point(), $urandom_range(0, 3), 1'b1);
        endcase
      end
      19: ;  // leave open, the noise that follows lands inside
      default: send_word(CH_QUOTE, 1'b0);
    endcase
  endtask

  initial begin
    int strings_sent;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    decoder_model     = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(CH_QUOTE, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_unicode(16'hD800, 4, 1'b0);
    send_unicode(16'h0000, 4, 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_LOWER_Q, 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_unicode(16'h0000, 0, 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);

    strings_sent = 0;
    while (words_sent < ITEM_TARGET) begin
      if (strings_sent == 12) hold_request = 1'b1;
      steady = (strings_sent >= 4 && strings_sent < 10);
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b1);
        else send_outside_byte();
      end
      send_random_string();
      strings_sent++;
    end

    steady = 1'b0;
    repeat (4) send_random_string();
    in_ch.valid <= 1'b0;

    while (decoder_model.expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (decoder_model.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: json_string_unescape_core.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_stream_ifs.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_serialize.sv
hw/rtl/json_string_unescape_core.sv
dv/json_string_unescape_core_tb.sv
